FILE: sv/lkv_pkg.sv
// Package for the LRU key-value cache: widths, reset constants, FSM states, control structs.
`default_nettype none
package lkv_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 64;
    localparam int CAP_W       = 7;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_COMMIT,
        ST_RESULT
    } lkv_state_t;

    // how the rank of one entry changes during the update pass
    typedef struct packed {
        logic hit;
        logic evict;
    } lkv_rule_t;

    typedef struct packed {
        logic key_eq;
        logic lru_eq;
    } lkv_cmp_t;

endpackage
`default_nettype wire

FILE: sv/lkv_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module lkv_ram
#(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/lkv_scan_unit.sv
// Shared per-entry unit: key and LRU compare, next recency rank.
`default_nettype none
module lkv_scan_unit
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  wire logic [KEY_W-1:0] stored_key,
    input  wire logic [IW-1:0]    stored_rank,
    input  wire logic [IW-1:0]    idx,
    input  wire logic [KEY_W-1:0] probe_key,
    input  wire logic [IW-1:0]    lru_rank,
    input  wire logic [IW-1:0]    ref_rank,
    input  wire logic [IW-1:0]    sel_slot,
    input  wire lkv_rule_t        rule,
    output lkv_cmp_t              flags,
    output logic      [IW-1:0]    new_rank
);

    logic [IW-1:0] rank_inc;

    assign rank_inc     = stored_rank + IW'(1);
    assign flags.key_eq = (stored_key == probe_key);
    assign flags.lru_eq = (stored_rank == lru_rank);

    always_comb
    begin
        if ((idx == sel_slot) && (rule.hit || rule.evict))
        begin
            new_rank = '0;
        end
        else if (rule.hit)
        begin
            new_rank = (stored_rank < ref_rank) ? rank_inc : stored_rank;
        end
        else
        begin
            new_rank = rank_inc;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: sequencer, entry stores, result registers.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  command   | start / busy          | mode, key, value
//  result    | done (1-cycle strobe) | hit, read_value, evicted, evicted_key
//  config    | capacity_we           | capacity_wdata
//
// Entries fill slots 0..N-1 in order; N is the fill count. A beat runs from accept to done
// through a match pass, a rank update pass and a commit step (the last two skipped on a
// get miss), then a result step; each pass scans the key/rank RAMs one entry per cycle.
// busy is high until done.
// Reset clears the fill count and sets capacity to CAPACITY_RESET; the RAMs need no clearing pass.
// The receiver cannot stall; done marks each result for one cycle.
`default_nettype none
module lru_key_value_cache_core
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             mode,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [VAL_W-1:0] value,
    output logic                  done,
    output logic                  hit,
    output logic      [VAL_W-1:0] read_value,
    output logic                  evicted,
    output logic      [KEY_W-1:0] evicted_key,
    input  wire logic             capacity_we,
    input  wire logic [CAP_W-1:0] capacity_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    lkv_state_t state_reg, state_next;

    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CAP_W-1:0] cap_reg;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic             evict_reg, evict_next;

    logic             mode_reg, mode_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic [IW-1:0]    fslot_reg, fslot_next;
    logic [IW-1:0]    frank_reg, frank_next;
    logic [IW-1:0]    lslot_reg, lslot_next;
    logic [KEY_W-1:0] lkey_reg, lkey_next;
    logic             hit_reg, hit_next;
    logic [VAL_W-1:0] rv_reg, rv_next;
    logic             ev_reg, ev_next;
    logic [KEY_W-1:0] evk_reg, evk_next;

    logic             issue;
    logic             pass_end;
    logic             rank_we, key_we, val_we;
    logic [IW-1:0]    rank_waddr, slot_waddr;
    logic [IW-1:0]    rank_wdata;
    logic [IW-1:0]    target_slot;

    logic [KEY_W-1:0] key_rd;
    logic [IW-1:0]    rank_rd;
    logic [VAL_W-1:0] val_rd;

    logic [CW-1:0]    count_dec;
    logic [EW-1:0]    cap_ext, count_ext, eff_cap;
    logic             evict_now;

    lkv_rule_t        rule;
    lkv_cmp_t         flags;
    logic [IW-1:0]    new_rank;

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rv_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;

    assign count_dec = count_reg - CW'(1);
    assign cap_ext   = EW'(cap_reg);
    assign count_ext = EW'(count_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (cap_ext > EW'(ENTRIES))
        begin
            eff_cap = EW'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict_now = mode_reg && !found_reg && (count_ext >= eff_cap) && (count_reg != '0);

    assign rule.hit    = found_reg;
    assign rule.evict  = evict_reg;
    assign target_slot = found_reg ? fslot_reg : (evict_reg ? lslot_reg : count_reg[IW-1:0]);

    lkv_scan_unit #(.ENTRIES(ENTRIES)) u_scan
    (
        .stored_key  (key_rd),
        .stored_rank (rank_rd),
        .idx         (pidx_reg),
        .probe_key   (key_reg),
        .lru_rank    (count_dec[IW-1:0]),
        .ref_rank    (frank_reg),
        .sel_slot    (found_reg ? fslot_reg : lslot_reg),
        .rule        (rule),
        .flags       (flags),
        .new_rank    (new_rank)
    );

    lkv_ram #(.W(KEY_W), .D(ENTRIES)) u_keys
    (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot_waddr),
        .wdata (key_reg),
        .raddr (idx_reg[IW-1:0]),
        .rdata (key_rd)
    );

    lkv_ram #(.W(VAL_W), .D(ENTRIES)) u_values
    (
        .clk   (clk),
        .we    (val_we),
        .waddr (slot_waddr),
        .wdata (value_reg),
        .raddr (fslot_reg),
        .rdata (val_rd)
    );

    lkv_ram #(.W(IW), .D(ENTRIES)) u_ranks
    (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rank_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = (found_reg || mode_reg) ? ST_UPDATE : ST_RESULT;
                end
            end
            ST_UPDATE:
            begin
                if (pass_end)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        issue      = 1'b0;
        rank_we    = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        rank_waddr = pidx_reg;
        rank_wdata = new_rank;
        slot_waddr = target_slot;
        case (state_reg)
            ST_SCAN:
            begin
                issue = (idx_reg < count_reg);
            end
            ST_UPDATE:
            begin
                issue   = (idx_reg < count_reg);
                rank_we = pend_reg;
            end
            ST_COMMIT:
            begin
                rank_waddr = target_slot;
                rank_wdata = '0;
                rank_we    = mode_reg;
                val_we     = mode_reg;
                key_we     = mode_reg && !found_reg;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
        pass_end = !issue && !pend_reg;
    end

    // datapath
    always_comb
    begin
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        count_next = count_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        evict_next = evict_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        value_next = value_reg;
        pidx_next  = pidx_reg;
        fslot_next = fslot_reg;
        frank_next = frank_reg;
        lslot_next = lslot_reg;
        lkey_next  = lkey_reg;
        hit_next   = hit_reg;
        rv_next    = rv_reg;
        ev_next    = ev_reg;
        evk_next   = evk_reg;

        if (issue)
        begin
            idx_next  = idx_reg + CW'(1);
            pend_next = 1'b1;
            pidx_next = idx_reg[IW-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    key_next   = key;
                    value_next = value;
                    idx_next   = '0;
                    found_next = 1'b0;
                    evict_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (flags.key_eq && !found_reg)
                    begin
                        found_next = 1'b1;
                        fslot_next = pidx_reg;
                        frank_next = rank_rd;
                    end
                    if (flags.lru_eq)
                    begin
                        lslot_next = pidx_reg;
                        lkey_next  = key_rd;
                    end
                end
                if (pass_end)
                begin
                    idx_next   = '0;
                    evict_next = evict_now;
                end
            end
            ST_COMMIT:
            begin
                if (mode_reg && !found_reg && !evict_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_RESULT:
            begin
                done_next = 1'b1;
                hit_next  = found_reg;
                rv_next   = (!mode_reg && found_reg) ? val_rd : '0;
                ev_next   = evict_reg;
                evk_next  = evict_reg ? lkey_reg : '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            cap_reg   <= CAPACITY_RESET;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            evict_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            evict_reg <= evict_next;
            if (capacity_we)
            begin
                cap_reg <= capacity_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        pidx_reg  <= pidx_next;
        fslot_reg <= fslot_next;
        frank_reg <= frank_next;
        lslot_reg <= lslot_next;
        lkey_reg  <= lkey_next;
        hit_reg   <= hit_next;
        rv_reg    <= rv_next;
        ev_reg    <= ev_next;
        evk_reg   <= evk_next;
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done strobe longer than one cycle");

    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ev_reg) |-> !hit_reg)
        else $error("eviction reported on a hit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= EW'(ENTRIES))
        else $error("fill count above store depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && (state_reg == ST_SCAN)))
        else $error("accepted beat did not start a scan");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !hit_reg) |-> (rv_reg == '0))
        else $error("read value nonzero on a miss");
`endif

endmodule
`default_nettype wire
